/* hw/rtl/assert_macros.svh */
// Assertion macros included by the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mlr_pkg.sv */
// Package for the midpoint line rasterizer: constants, codes and control structs.
`default_nettype none

package mlr_pkg;

    // Default coordinate width of the screen space.
    localparam int COORD_BITS_DEF = 12;

    // Opcodes carried in the input item's tuser.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Octant mappings into the shallow, rising frame.
    localparam logic [1:0] OCT_DIRECT = 2'd0;  // (x, y)
    localparam logic [1:0] OCT_SWAP   = 2'd1;  // (y, x)
    localparam logic [1:0] OCT_ROT    = 2'd2;  // (-y, x)
    localparam logic [1:0] OCT_MIRROR = 2'd3;  // (-x, y)

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // Latch the endpoints of a start item.
        logic setup;     // Compute the octant and the mapped endpoints.
        logic load;      // Order the endpoints, load the line and emit the first pixel.
        logic advance;   // Take one step and emit the next pixel.
    } mlr_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/mlr_ctrl.sv */
// Controller of the midpoint line rasterizer: handshakes and command sequencing.
`default_nettype none

module mlr_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    input  wire logic            opcode,
    input  wire logic            m_tready,
    output logic                 s_tready,
    output logic                 m_tvalid,
    output mlr_pkg::mlr_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_LOAD  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;

    // Take an item only when idle and the output register is free or draining.
    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;

    // Next state and commands.
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (opcode == mlr_pkg::OP_START) begin
                        cmd.capture = 1'b1;
                        state_next  = ST_SETUP;
                    end else begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output item is valid once written and stays until taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load || cmd.advance) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mlr_dp.sv */
// Datapath of the midpoint line rasterizer: octant set-up, stepping and pixel output.
`default_nettype none

module mlr_dp #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire mlr_pkg::mlr_cmd_t       cmd,
    input  wire logic [4*COORD_BITS-1:0] in_coords,
    output logic [COORD_BITS-1:0]        out_x,
    output logic [COORD_BITS-1:0]        out_y,
    output logic                         out_pix_valid,
    output logic                         out_last
);

    localparam int C = COORD_BITS;
    localparam int M = COORD_BITS + 1;   // Mapped coordinates.
    localparam int S = COORD_BITS + 3;   // Increments.
    localparam int D = COORD_BITS + 4;   // Decision variable.

    // Captured endpoints.
    logic signed [C-1:0] x0_reg, y0_reg, x1_reg, y1_reg;

    // Mapped endpoints and octant from the set-up step.
    logic signed [M-1:0] p0_reg, q0_reg, p1_reg, q1_reg;
    logic [1:0]          octant_map_reg, octant_next;

    // Line state.
    logic signed [M-1:0] major_pos_reg, minor_pos_reg, major_end_reg;
    logic signed [D-1:0] decision_reg;
    logic signed [S-1:0] step_east_reg, step_diag_reg;
    logic                active_reg;

    // Output register.
    logic [C-1:0] out_x_reg, out_y_reg;
    logic         out_pix_valid_reg, out_last_reg;

    // Set-up signals.
    logic signed [M-1:0] x0m, y0m, x1m, y1m, mx, my;
    logic        [M-1:0] ax, ay;
    logic                mx_zero, my_zero, agree;
    logic signed [M-1:0] p0_next, q0_next, p1_next, q1_next;

    // Load signals.
    logic                le;
    logic signed [M-1:0] a_init, b_init, e_init, c_init;
    logic signed [S-1:0] dmaj, dmin, diff, east_init, diag_init;
    logic signed [D-1:0] dec_init;

    // Step signals.
    logic                dec_le0;
    logic signed [D-1:0] dec_adv;
    logic signed [M-1:0] major_adv, minor_adv;
    logic                active_adv;

    // Pixel mapping back to screen space.
    logic signed [M-1:0] em_a, em_b, em_neg_a;
    logic [C-1:0]        px, py;

    // Capture the endpoints of a start item.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x0_reg <= in_coords[C-1:0];
            y0_reg <= in_coords[2*C-1:C];
            x1_reg <= in_coords[3*C-1:2*C];
            y1_reg <= in_coords[4*C-1:3*C];
        end
    end

    // Deltas, their magnitudes and the octant choice.
    always_comb begin
        x0m     = M'(x0_reg);
        y0m     = M'(y0_reg);
        x1m     = M'(x1_reg);
        y1m     = M'(y1_reg);
        mx      = x1m - x0m;
        my      = y1m - y0m;
        ax      = mx[M-1] ? M'(-mx) : M'(mx);
        ay      = my[M-1] ? M'(-my) : M'(my);
        mx_zero = (mx == '0);
        my_zero = (my == '0);
        agree   = (!mx[M-1] && !mx_zero && !my[M-1]) || (mx[M-1] && (my[M-1] || my_zero));
        if (mx_zero) begin
            octant_next = mlr_pkg::OCT_SWAP;
        end else if (agree) begin
            octant_next = (ay <= ax) ? mlr_pkg::OCT_DIRECT : mlr_pkg::OCT_SWAP;
        end else begin
            octant_next = (ay >= ax) ? mlr_pkg::OCT_ROT : mlr_pkg::OCT_MIRROR;
        end
        case (octant_next)
            mlr_pkg::OCT_DIRECT: begin
                p0_next = x0m;  q0_next = y0m;  p1_next = x1m;  q1_next = y1m;
            end
            mlr_pkg::OCT_SWAP: begin
                p0_next = y0m;  q0_next = x0m;  p1_next = y1m;  q1_next = x1m;
            end
            mlr_pkg::OCT_ROT: begin
                p0_next = -y0m; q0_next = x0m;  p1_next = -y1m; q1_next = x1m;
            end
            default: begin
                p0_next = -x0m; q0_next = y0m;  p1_next = -x1m; q1_next = y1m;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            p0_reg         <= p0_next;
            q0_reg         <= q0_next;
            p1_reg         <= p1_next;
            q1_reg         <= q1_next;
            octant_map_reg <= octant_next;
        end
    end

    // Order the mapped endpoints by major coordinate and derive the increments.
    always_comb begin
        le        = (p0_reg <= p1_reg);
        a_init    = le ? p0_reg : p1_reg;
        b_init    = le ? q0_reg : q1_reg;
        e_init    = le ? p1_reg : p0_reg;
        c_init    = le ? q1_reg : q0_reg;
        dmaj      = S'(e_init) - S'(a_init);
        dmin      = S'(c_init) - S'(b_init);
        diff      = dmin - dmaj;
        east_init = {dmin[S-2:0], 1'b0};
        diag_init = {diff[S-2:0], 1'b0};
        dec_init  = D'(east_init) - D'(dmaj);
    end

    // One midpoint step.
    always_comb begin
        dec_le0    = decision_reg[D-1] || (decision_reg == '0);
        dec_adv    = decision_reg + (dec_le0 ? D'(step_east_reg) : D'(step_diag_reg));
        minor_adv  = dec_le0 ? minor_pos_reg : minor_pos_reg + M'(1);
        major_adv  = major_pos_reg + M'(1);
        active_adv = (major_adv < major_end_reg);
    end

    // Line state updates.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            major_pos_reg <= a_init;
            minor_pos_reg <= b_init;
            major_end_reg <= e_init;
            decision_reg  <= dec_init;
            step_east_reg <= east_init;
            step_diag_reg <= diag_init;
        end else if (cmd.advance && active_reg) begin
            major_pos_reg <= major_adv;
            minor_pos_reg <= minor_adv;
            decision_reg  <= dec_adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (cmd.load) begin
            active_reg <= (a_init != e_init);
        end else if (cmd.advance && active_reg) begin
            active_reg <= active_adv;
        end
    end

    // Map the new position back to screen space.
    always_comb begin
        em_a     = cmd.load ? a_init : major_adv;
        em_b     = cmd.load ? b_init : minor_adv;
        em_neg_a = -em_a;
        case (octant_map_reg)
            mlr_pkg::OCT_DIRECT: begin
                px = em_a[C-1:0];     py = em_b[C-1:0];
            end
            mlr_pkg::OCT_SWAP: begin
                px = em_b[C-1:0];     py = em_a[C-1:0];
            end
            mlr_pkg::OCT_ROT: begin
                px = em_b[C-1:0];     py = em_neg_a[C-1:0];
            end
            default: begin
                px = em_neg_a[C-1:0]; py = em_b[C-1:0];
            end
        endcase
    end

    // Output register; an advance with no active line gives an empty pixel.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_x_reg         <= px;
            out_y_reg         <= py;
            out_pix_valid_reg <= 1'b1;
            out_last_reg      <= (a_init == e_init);
        end else if (cmd.advance) begin
            if (active_reg) begin
                out_x_reg         <= px;
                out_y_reg         <= py;
                out_pix_valid_reg <= 1'b1;
                out_last_reg      <= !active_adv;
            end else begin
                out_x_reg         <= '0;
                out_y_reg         <= '0;
                out_pix_valid_reg <= 1'b0;
                out_last_reg      <= 1'b0;
            end
        end
    end

    assign out_x         = out_x_reg;
    assign out_y         = out_y_reg;
    assign out_pix_valid = out_pix_valid_reg;
    assign out_last      = out_last_reg;

endmodule

`default_nettype wire

/* hw/rtl/midpoint_line_rasterizer_unit.sv */
// Midpoint line rasterizer: walks a line segment one pixel per advance item.
// Input channel (s_): tuser is the opcode, tdata the endpoints. A start item
// loads a line and returns its first pixel; each advance item returns the next
// pixel, with tlast on the final one. Advances with no active line return an
// item with tuser (pixel valid) low.
// Output channel (m_): one item per input item, in order.
// An advance item's result appears the cycle after acceptance; a start item
// passes through capture, octant set-up, and ordering and load, and the input
// is held off during octant set-up and during ordering and load.
// Throughput: one advance item per cycle while the receiver takes results; the
// single step is one add and one compare on the decision variable.
// Reset (aresetn low, synchronous) clears the controller and ends any active line.
// When the receiver stalls, the finished item is held in the output register and
// a new item is accepted only in the cycle in which that item is taken.
`default_nettype none
`include "assert_macros.svh"

module midpoint_line_rasterizer_unit #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF,
    localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // x_start, y_start, x_end, y_end
    input  wire logic             s_tuser,   // opcode
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // pixel_x, pixel_y
    output logic                  m_tuser,   // pixel_valid
    output logic                  m_tlast    // last
);

    mlr_pkg::mlr_cmd_t       cmd;
    logic [COORD_BITS-1:0]   pix_x, pix_y;

    mlr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .opcode   (s_tuser),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    mlr_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_coords     (s_tdata[4*COORD_BITS-1:0]),
        .out_x         (pix_x),
        .out_y         (pix_y),
        .out_pix_valid (m_tuser),
        .out_last      (m_tlast)
    );

    // Pack the pixel, padding to whole bytes.
    generate
        if (OUT_W > 2 * COORD_BITS) begin : g_pad
            assign m_tdata = {{(OUT_W - 2 * COORD_BITS){1'b0}}, pix_y, pix_x};
        end else begin : g_nopad
            assign m_tdata = {pix_y, pix_x};
        end
    endgenerate

    // Set-up steps never overlap with accepting an item.
    `ASSERT_IMPL(a_setup_blocks_in, aclk, aresetn, cmd.setup || cmd.load, !s_tready, "item accepted during line set-up")
    // A captured start item runs through both set-up steps.
    `ASSERT_NEXT(a_capture_then_setup, aclk, aresetn, cmd.capture, cmd.setup, "capture not followed by set-up")
    `ASSERT_NEXT(a_setup_then_load, aclk, aresetn, cmd.setup, cmd.load, "set-up not followed by load")
    // An empty result is never the final pixel of a line.
    `ASSERT_IMPL(a_empty_not_last, aclk, aresetn, m_tvalid && !m_tuser, !m_tlast, "empty item marked last")
    // At most one command per cycle.
    `ASSERT_IMPL(a_one_cmd, aclk, aresetn, 1'b1, $onehot0(cmd), "several datapath commands at once")

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the midpoint line rasterizer with its own pixel predictor.

module tb_top;

    localparam int CB         = mlr_pkg::COORD_BITS_DEF;
    localparam int IN_W       = ((4 * CB + 7) / 8) * 8;
    localparam int OUT_W      = ((2 * CB + 7) / 8) * 8;
    localparam int CYCLE_CAP  = 400000;
    localparam int RAND_ITEMS = 1000;
    localparam int CMAX       = (1 << (CB - 1)) - 1;
    localparam int CMIN       = -(1 << (CB - 1));

    // One expected output item.
    typedef struct packed {
        logic [CB-1:0] px;
        logic [CB-1:0] py;
        logic          valid;
        logic          last;
    } pixel_t;

    // Line walker state mirrored from the design, plus the queue of pixels still due.
    class raster_scoreboard;
        logic signed [CB:0]   major_pos, minor_pos, major_end;
        logic signed [CB+3:0] decision;
        logic signed [CB+2:0] step_east, step_diag;
        logic [1:0]           octant;
        bit                   active;
        pixel_t               expected_pixels[$];
        int                   items_in, compared, errors;
        int                   lines, pixels, invalids;
        int                   octant_hits[4];

        function new();
            major_pos = '0; minor_pos = '0; major_end = '0;
            decision = '0; step_east = '0; step_diag = '0;
            octant = mlr_pkg::OCT_DIRECT; active = 1'b0;
            items_in = 0; compared = 0; errors = 0;
            lines = 0; pixels = 0; invalids = 0;
            foreach (octant_hits[i]) octant_hits[i] = 0;
        endfunction

        // Map the current walker position back to screen space and queue it.
        function void push_pixel(bit is_last);
            int a, b, px, py;
            pixel_t p;
            a = int'(major_pos);
            b = int'(minor_pos);
            case (octant)
                mlr_pkg::OCT_DIRECT: begin px = a;  py = b;  end
                mlr_pkg::OCT_SWAP:   begin px = b;  py = a;  end
                mlr_pkg::OCT_ROT:    begin px = b;  py = -a; end
                default:             begin px = -a; py = b;  end
            endcase
            p.px    = px[CB-1:0];
            p.py    = py[CB-1:0];
            p.valid = 1'b1;
            p.last  = is_last;
            expected_pixels.push_back(p);
            pixels++;
        endfunction

        // Works out the pixel that an accepted input item produces.
        function void predict_item(logic op, logic [IN_W-1:0] data);
            int x0, y0, x1, y1, mx, my, ax, ay;
            int p0, q0, p1, q1, dmaj, dmin;
            bit agree;
            pixel_t none;
            items_in++;
            if (op == mlr_pkg::OP_START) begin
                x0 = int'($signed(data[0*CB +: CB]));
                y0 = int'($signed(data[1*CB +: CB]));
                x1 = int'($signed(data[2*CB +: CB]));
                y1 = int'($signed(data[3*CB +: CB]));
                mx = x1 - x0;
                my = y1 - y0;
                ax = (mx < 0) ? -mx : mx;
                ay = (my < 0) ? -my : my;
                agree = (mx > 0 && my >= 0) || (mx < 0 && my <= 0);
                // Vertical lines count as steep.
                if (mx == 0)
                    octant = mlr_pkg::OCT_SWAP;
                else if (agree)
                    octant = (ay <= ax) ? mlr_pkg::OCT_DIRECT : mlr_pkg::OCT_SWAP;
                else
                    octant = (ay >= ax) ? mlr_pkg::OCT_ROT : mlr_pkg::OCT_MIRROR;
                case (octant)
                    mlr_pkg::OCT_DIRECT: begin p0 = x0;  q0 = y0; p1 = x1;  q1 = y1; end
                    mlr_pkg::OCT_SWAP:   begin p0 = y0;  q0 = x0; p1 = y1;  q1 = x1; end
                    mlr_pkg::OCT_ROT:    begin p0 = -y0; q0 = x0; p1 = -y1; q1 = x1; end
                    default:             begin p0 = -x0; q0 = y0; p1 = -x1; q1 = y1; end
                endcase
                // Walk from the lower major coordinate upward.
                if (p0 <= p1) begin
                    major_pos = (CB+1)'(p0); minor_pos = (CB+1)'(q0); major_end = (CB+1)'(p1);
                    dmaj = p1 - p0; dmin = q1 - q0;
                end else begin
                    major_pos = (CB+1)'(p1); minor_pos = (CB+1)'(q1); major_end = (CB+1)'(p0);
                    dmaj = p0 - p1; dmin = q0 - q1;
                end
                decision  = (CB+4)'(2 * dmin - dmaj);
                step_east = (CB+3)'(2 * dmin);
                step_diag = (CB+3)'(2 * (dmin - dmaj));
                active = (major_pos != major_end);
                lines++;
                octant_hits[octant]++;
                push_pixel(!active);
            end else if (!active) begin
                // Advance with no line in flight returns an empty item.
                none = '0;
                expected_pixels.push_back(none);
                invalids++;
            end else begin
                if (decision <= 0) begin
                    decision = decision + (CB+4)'(step_east);
                end else begin
                    decision  = decision + (CB+4)'(step_diag);
                    minor_pos = minor_pos + (CB+1)'(1);
                end
                major_pos = major_pos + (CB+1)'(1);
                active = (major_pos < major_end);
                push_pixel(!active);
            end
        endfunction

        // Compares one output item with the oldest pixel still due.
        function void check_pixel(logic [OUT_W-1:0] data, logic valid, logic last);
            pixel_t want, got;
            string  exp_s, got_s;
            got.px    = data[0 +: CB];
            got.py    = data[CB +: CB];
            got.valid = valid;
            got.last  = last;
            compared++;
            if (expected_pixels.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("tb_top: unexpected output item x=%0d y=%0d valid=%0b last=%0b",
                             $signed(got.px), $signed(got.py), got.valid, got.last);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.px !== want.px || got.py !== want.py ||
                got.valid !== want.valid || got.last !== want.last) begin
                errors++;
                if (errors <= 10) begin
                    exp_s = $sformatf("x=%0d y=%0d valid=%0b last=%0b",
                                      $signed(want.px), $signed(want.py),
                                      want.valid, want.last);
                    got_s = $sformatf("x=%0d y=%0d valid=%0b last=%0b",
                                      $signed(got.px), $signed(got.py),
                                      got.valid, got.last);
                    $display("tb_top: mismatch on output item %0d: expected %s, got %s",
                             compared, exp_s, got_s);
                end
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tuser;
    logic             m_tlast;

    raster_scoreboard sb;
    bit               sender_burst;
    int               cycles;

    midpoint_line_rasterizer_unit #(
        .COORD_BITS(CB)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // 2 ns clock.
    initial begin
        forever #1 aclk = ~aclk;
    end

    // Cycle budget for the whole run.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_CAP) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    // Every output item taken by the receiver is checked.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_pixel(m_tdata, m_tuser, m_tlast);
    end

    // Receiver: random back-pressure in stretches, with one long hold-off.
    initial begin : receiver
        int hold_left, mode, mode_left;
        bit held_once;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        held_once = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held_once && sb.items_in >= 400) begin
                held_once = 1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(2);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: begin
                        m_tready <= ($urandom_range(3) != 0);
                        if ($urandom_range(99) == 0)
                            hold_left = $urandom_range(20, 50);
                    end
                    default: m_tready <= ($urandom_range(3) == 0);
                endcase
            end
            @(posedge aclk);
        end
    end

    // Idle cycles before the next item: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        if (sender_burst)
            return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [IN_W-1:0] pack_ends(int x0, int y0, int x1, int y1);
        logic [IN_W-1:0] d;
        d = '0;
        d[0*CB +: CB] = x0[CB-1:0];
        d[1*CB +: CB] = y0[CB-1:0];
        d[2*CB +: CB] = x1[CB-1:0];
        d[3*CB +: CB] = y1[CB-1:0];
        return d;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(CMAX - CMIN)) + CMIN;
    endfunction

    // Offers one item and returns once it has been accepted.
    task automatic send_item(logic op, logic [IN_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.predict_item(op, data);
    endtask

    task automatic send_start(int x0, int y0, int x1, int y1);
        send_item(mlr_pkg::OP_START, pack_ends(x0, y0, x1, y1));
    endtask

    // Advance items carry random endpoint bits, which the block ignores.
    task automatic send_advances(int n);
        repeat (n) send_item(mlr_pkg::OP_ADVANCE, IN_W'({$urandom, $urandom}));
    endtask

    // Picks the second endpoint near the first, with ties and axis-aligned cases now and then.
    task automatic short_line(output int x0, output int y0, output int x1, output int y1);
        int dx, dy, r;
        x0 = rand_coord();
        y0 = rand_coord();
        dx = int'($urandom_range(48)) - 24;
        dy = int'($urandom_range(48)) - 24;
        r = $urandom_range(9);
        if (r == 0) dx = 0;
        else if (r == 1) dy = 0;
        else if (r == 2) dy = ($urandom_range(1) != 0) ? dx : -dx;
        x1 = x0 + dx;
        y1 = y0 + dy;
        if (x1 > CMAX || x1 < CMIN) x1 = x0 - dx;
        if (y1 > CMAX || y1 < CMIN) y1 = y0 - dy;
    endtask

    // Main sequence: reset, directed lines, random lines, drain.
    initial begin : stimulus
        int x0, y0, x1, y1, len, adv, r, sent, extra;
        sb = new();
        sender_burst = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Advance with no active line.
        send_advances(1);
        // Single point, then an advance past its end.
        send_start(5, -7, 5, -7);
        send_advances(1);
        // Vertical line upward, walked to the end.
        send_start(0, 0, 0, 2);
        send_advances(2);
        // Horizontal line drawn right to left.
        send_start(2, 0, 0, 0);
        send_advances(2);
        // Steep line with agreeing signs.
        send_start(1, 1, 2, 3);
        send_advances(2);
        // Steep line with opposing signs.
        send_start(0, 0, -1, 2);
        send_advances(2);
        // Shallow line with opposing signs.
        send_start(0, 0, 2, -1);
        send_advances(2);
        // Extreme diagonals, each abandoned by the next start.
        send_start(CMIN, CMIN, CMAX, CMAX);
        send_advances(2);
        send_start(CMAX, CMIN, CMIN, CMAX);
        send_advances(2);
        // Full-height vertical line, abandoned.
        send_start(CMIN, CMAX, CMIN, CMIN);
        send_advances(2);

        // Random part: mostly complete short lines, some wide ones, some noise.
        sent = 0;
        while (sent < RAND_ITEMS) begin
            if ($urandom_range(15) == 0)
                sender_burst = ($urandom_range(2) == 0);
            r = $urandom_range(99);
            if (r < 75) begin
                short_line(x0, y0, x1, y1);
                len = (x1 > x0) ? x1 - x0 : x0 - x1;
                if (((y1 > y0) ? y1 - y0 : y0 - y1) > len)
                    len = (y1 > y0) ? y1 - y0 : y0 - y1;
                extra = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
                adv = ($urandom_range(9) == 0) ? $urandom_range(len) : len + extra;
                send_start(x0, y0, x1, y1);
                send_advances(adv);
                sent += adv + 1;
            end else if (r < 90) begin
                adv = $urandom_range(6);
                send_start(rand_coord(), rand_coord(), rand_coord(), rand_coord());
                send_advances(adv);
                sent += adv + 1;
            end else begin
                send_advances($urandom_range(1, 3));
            end
        end
        s_tvalid <= 1'b0;

        // Drain the remaining pixels, then let the pipeline settle.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("tb_top: %0d lines started (mappings %0d/%0d/%0d/%0d), %0d pixels, %0d empty",
                 sb.lines, sb.octant_hits[0], sb.octant_hits[1], sb.octant_hits[2],
                 sb.octant_hits[3], sb.pixels, sb.invalids);
        $display("tb_top: %0d input items, %0d output items compared, %0d errors",
                 sb.items_in, sb.compared, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
